>>> rtl/positional_insert_delete_array_defines.svh
// Assertion helpers for the top-level RTL file.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pida_pkg.sv
package pida_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // common width for index/position/count compares
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2
  } pida_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pida_status_e;

  typedef struct packed {
    pida_mode_e                mode;
    logic [POS_W-1:0]          position;
    logic signed [WORD_W-1:0]  value_in;
  } pida_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  value_out;
    logic [COUNT_W-1:0]        count;
    pida_status_e              status;
  } pida_rsp_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic [CMP_W-1:0]          pos;
    logic [CMP_W-1:0]          cnt;
    logic [WORD_W-1:0]         word;
  } pida_cmd_t;

endpackage

>>> rtl/pida_cell.sv
module pida_cell (
  input  logic                          clk_i,
  input  logic [pida_pkg::IDX_W-1:0]    idx_i,
  input  pida_pkg::pida_cmd_t           cmd_i,
  input  logic [pida_pkg::WORD_W-1:0]   left_i,
  input  logic [pida_pkg::WORD_W-1:0]   right_i,
  output logic [pida_pkg::WORD_W-1:0]   word_o
);
  import pida_pkg::*;

  logic [WORD_W-1:0] word_q, word_d;
  logic [CMP_W-1:0]  idx_ext, idx_nxt;

  assign idx_ext = CMP_W'(idx_i);
  assign idx_nxt = idx_ext + CMP_W'(1);

  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (idx_ext == cmd_i.pos) begin
        word_d = cmd_i.word;
      end else if ((idx_ext > cmd_i.pos) && (idx_ext <= cmd_i.cnt)) begin
        word_d = left_i;   // make room: shift up
      end
    end else if (cmd_i.del) begin
      if ((idx_ext >= cmd_i.pos) && (idx_nxt < cmd_i.cnt)) begin
        word_d = right_i;  // close the gap: shift down
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> rtl/positional_insert_delete_array.sv
// Positional insert/delete array. Holds an ordered list of up to CAPACITY
// signed 32-bit words. Each request inserts a word at an index (later
// entries move up), deletes the entry at an index (later entries move
// down) or reads the entry at an index. A request is taken on a clock edge
// with start high and busy low; busy never rises, so a request can be
// issued every cycle. Its single response appears on rsp_o in the next cycle,
// marked by done_o for exactly one cycle. The receiver cannot stall: it
// must capture the response in that cycle. Responses carry the word read or
// removed (zero on insert and on any error), the entry count after the
// request, and a status: ok, full, empty, or position out of range. Every
// request is applied on its accepting edge, as each storage cell compares its
// own index against the broadcast position and takes its new word from
// itself, a neighbor or the request in the same clock. No clearing is done
// after reset: entries at or above the count are never visible.
module positional_insert_delete_array (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pida_pkg::pida_req_t  req_i,
  output logic                 done_o,
  output pida_pkg::pida_rsp_t  rsp_o
);
  import pida_pkg::*;
  `include "positional_insert_delete_array_defines.svh"

  logic              accept;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q;
  pida_rsp_t         rsp_q, rsp_d;
  pida_cmd_t         cmd;
  logic [CMP_W-1:0]  pos_ext, cnt_ext, cnt_d_ext;
  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [WORD_W-1:0] rd_word;

  // No multi-cycle work: always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext = CMP_W'(req_i.position);
  assign cnt_ext = CMP_W'(cnt_q);

  // Read port: pos is only used when in range, so the low bits suffice.
  assign rd_word = cell_word[pos_ext[IDX_W-1:0]];

  // Request decode and status checks. Full/empty take priority over range.
  always_comb begin
    cmd.ins  = 1'b0;
    cmd.del  = 1'b0;
    cmd.pos  = pos_ext;
    cmd.cnt  = cnt_ext;
    cmd.word = req_i.value_in;
    cnt_d    = cnt_q;
    rsp_d.value_out = '0;
    rsp_d.status    = ST_OK;
    if (accept) begin
      unique case (req_i.mode)
        MODE_INSERT: begin
          if (cnt_ext >= CMP_W'(CAPACITY)) begin
            rsp_d.status = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            rsp_d.status = ST_RANGE;
          end else begin
            cmd.ins = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        MODE_DELETE, MODE_READ: begin
          if (cnt_q == '0) begin
            rsp_d.status = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            rsp_d.status = ST_RANGE;
          end else begin
            rsp_d.value_out = rd_word;
            if (req_i.mode == MODE_DELETE) begin
              cmd.del = 1'b1;
              cnt_d   = cnt_q - CNT_W'(1);
            end
          end
        end
        default: begin
          // unused mode code: no effect
          rsp_d.status = ST_RANGE;
        end
      endcase
    end
    cnt_d_ext   = CMP_W'(cnt_d);
    rsp_d.count = cnt_d_ext[COUNT_W-1:0];
  end

  // Row of storage cells; each sees its neighbors' words.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[k+1];
    end
    pida_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(k)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `PIDA_ASSERT_NOW(a_cnt_bound, 1'b1, CMP_W'(cnt_q) <= CMP_W'(CAPACITY), "count above capacity")
  `PIDA_ASSERT_NEXT(a_done_follows, accept, done_q, "accepted request without response")
  `PIDA_ASSERT_NEXT(a_no_spurious, !accept, !done_q, "response without request")
  `PIDA_ASSERT_NEXT(a_cnt_hold, !accept, $stable(cnt_q), "count moved while idle")
  `PIDA_ASSERT_NOW(a_err_zero, done_q && (rsp_q.status != ST_OK), rsp_q.value_out == '0, "error response carries data")

endmodule

>>> verif/positional_insert_delete_array_checker.sv
`timescale 1ns / 100ps

// Watches the request and response channels of the insert/delete array,
// tracks the list contents and compares every response in order.
module positional_insert_delete_array_checker
  import pida_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  pida_req_t  req_i,
  input  logic       done_i,
  input  pida_rsp_t  rsp_i,
  output int         mismatches_o,
  output int         pending_o,
  output int         checked_o
);

  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int                       list_len = 0;
  pida_rsp_t                expected_rsps [$];
  int                       n_mismatch = 0;
  int                       n_checked = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  // Applies one request to the tracked list, returns the response it earns.
  function automatic pida_rsp_t apply_request(input pida_req_t r);
    pida_rsp_t o;
    int        p;
    o.value_out = '0;
    o.status    = ST_OK;
    p = int'(r.position);
    case (r.mode)
      MODE_INSERT: begin
        if (list_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else if (p > list_len) begin
          o.status = ST_RANGE;
        end else begin
          for (int k = list_len; k > p; k--) list_words[k] = list_words[k-1];
          list_words[p] = r.value_in;
          list_len++;
        end
      end
      MODE_DELETE, MODE_READ: begin
        if (list_len == 0) begin
          o.status = ST_EMPTY;
        end else if (p >= list_len) begin
          o.status = ST_RANGE;
        end else begin
          o.value_out = list_words[p];
          if (r.mode == MODE_DELETE) begin
            for (int k = p; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
            list_len--;
          end
        end
      end
      default: o.status = ST_RANGE; // unused mode code
    endcase
    o.count = list_len[COUNT_W-1:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pida_rsp_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_rsps.delete();
      pending_o <= 0;
    end else begin
      // a response never shares an edge with its own request
      if (done_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.value_out !== want.value_out)
            report_mismatch($sformatf("value_out: expected %0d, got %0d",
                                      want.value_out, rsp_i.value_out));
          if (rsp_i.count !== want.count)
            report_mismatch($sformatf("count: expected %0d, got %0d",
                                      want.count, rsp_i.count));
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status: expected %0d, got %0d",
                                      want.status, rsp_i.status));
          n_checked++;
        end
      end
      if (start_i && !busy_i) expected_rsps.push_back(apply_request(req_i));
      pending_o    <= expected_rsps.size();
      mismatches_o <= n_mismatch;
      checked_o    <= n_checked;
    end
  end

endmodule

>>> verif/positional_insert_delete_array_test.sv
`timescale 1ns / 100ps

// Top of the insert/delete array testbench. Makes clock, reset and request
// traffic; the checker beside the block does all prediction and comparing.
module positional_insert_delete_array_test;
  import pida_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 1530;
  // window of the random part in which the sender never idles
  localparam int QUIET_FROM     = 600;
  localparam int QUIET_TO       = 900;
  // mode code 3 is not an operation; the block must answer it as out of range
  localparam pida_mode_e MODE_UNUSED = pida_mode_e'(2'd3);

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  pida_req_t req_i = '0;
  logic      done_o;
  pida_rsp_t rsp_o;

  int mismatches;
  int pending;
  int checked;

  // stimulus-side bookkeeping: just the entry count, to aim positions
  int list_len = 0;
  int n_sent = 0;
  int n_fills = 0;
  int n_empties = 0;
  int quiet_cycles = 0;

  always #CLK_HALF clk_i = ~clk_i;

  positional_insert_delete_array dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  positional_insert_delete_array_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Watchdog: any edge that moves a request or a response restarts it.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles with no traffic, %0d responses pending",
               quiet_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic pida_req_t make_req(input pida_mode_e m, input int pos,
                                         input logic signed [WORD_W-1:0] v);
    pida_req_t r;
    r.mode     = m;
    r.position = pos[POS_W-1:0];
    r.value_in = v;
    return r;
  endfunction

  // Holds start high until the block takes the request; the caller sits on
  // a rising edge, and start is only lowered by idle_cycle and drain, so
  // back-to-back requests keep start high without a lower/raise in one step.
  task automatic issue(input pida_req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_sent++;
    // follow the count so random positions can aim at the live range
    case (r.mode)
      MODE_INSERT: if (list_len < CAPACITY && int'(r.position) <= list_len) begin
        list_len++;
        if (list_len == CAPACITY) n_fills++;
      end
      MODE_DELETE: if (list_len > 0 && int'(r.position) < list_len) begin
        list_len--;
        if (list_len == 0) n_empties++;
      end
      default: ;
    endcase
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops sending and waits for every response still owed. The pending
  // count from the checker is registered, hence the first edge.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random request. While growing, inserts dominate so the list climbs to
  // capacity and bounces off it; while shrinking, deletes dominate down to
  // empty. Most positions land inside the legal range for the mode, the
  // rest span the whole 5-bit field.
  function automatic pida_req_t random_req(input bit growing);
    pida_mode_e                m;
    int                        roll;
    int                        pos;
    logic signed [WORD_W-1:0]  v;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 62)      m = MODE_INSERT;
      else if (roll < 80) m = MODE_READ;
      else if (roll < 96) m = MODE_DELETE;
      else                m = MODE_UNUSED;
    end else begin
      if (roll < 15)      m = MODE_INSERT;
      else if (roll < 35) m = MODE_READ;
      else if (roll < 96) m = MODE_DELETE;
      else                m = MODE_UNUSED;
    end
    if ($urandom_range(0, 99) < 85) begin
      if (m == MODE_INSERT)  pos = $urandom_range(0, list_len);
      else if (list_len > 0) pos = $urandom_range(0, list_len - 1);
      else                   pos = 0;
    end else begin
      pos = $urandom_range(0, (1 << POS_W) - 1);
    end
    case ($urandom_range(0, 19))
      0:       v = 32'sh7FFF_FFFF;
      1:       v = 32'sh8000_0000;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom();
    endcase
    return make_req(m, pos, v);
  endfunction

  initial begin
    bit growing;
    int n_directed;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list checks, edges of position, front/middle/back
    // insert and delete, word extremes, the unused mode code.
    issue(make_req(MODE_READ,   0,  32'sd0));           // empty
    issue(make_req(MODE_DELETE, 31, 32'sd0));           // empty wins over range
    issue(make_req(MODE_INSERT, 1,  32'sd7));           // past the end
    issue(make_req(MODE_UNUSED, 0,  32'sd9));
    issue(make_req(MODE_INSERT, 0,  32'sh7FFF_FFFF));
    issue(make_req(MODE_INSERT, 1,  32'sh8000_0000));   // at the back
    issue(make_req(MODE_INSERT, 0,  -32'sd1));          // at the front
    issue(make_req(MODE_INSERT, 1,  32'sd0));           // middle
    issue(make_req(MODE_INSERT, 5,  32'sd3));           // count is 4
    issue(make_req(MODE_READ,   0,  32'sd0));
    issue(make_req(MODE_READ,   3,  32'sd0));
    issue(make_req(MODE_READ,   4,  32'sd0));           // one past the end
    issue(make_req(MODE_READ,   31, 32'sd0));
    issue(make_req(MODE_UNUSED, 31, -32'sd1));
    issue(make_req(MODE_DELETE, 1,  32'sd0));           // middle
    issue(make_req(MODE_DELETE, 2,  32'sd0));           // back
    issue(make_req(MODE_DELETE, 2,  32'sd0));           // past the end
    issue(make_req(MODE_DELETE, 0,  32'sd0));           // front
    issue(make_req(MODE_READ,   0,  32'sd0));
    issue(make_req(MODE_DELETE, 0,  32'sd0));           // last entry
    issue(make_req(MODE_READ,   0,  32'sd0));           // empty again
    issue(make_req(MODE_INSERT, 0,  32'sh5A5A_5A5A));
    n_directed = n_sent;

    // hold off until the block has answered everything
    drain();

    growing = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < QUIET_FROM || i >= QUIET_TO)
        while ($urandom_range(0, 99) < 32) idle_cycle();
      issue(random_req(growing));
      // linger at the ends so full and empty cases get hit repeatedly
      if (growing && list_len == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (!growing && list_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
    end

    drain();
    repeat (4) @(posedge clk_i);

    $display("ran %0d requests (%0d directed), %0d responses checked",
             n_sent, n_directed, checked);
    $display("list went to capacity %0d times and back to empty %0d times",
             n_fills, n_empties);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
